// ----- rtl/ecs_pkg.sv -----
package ecs_pkg;

  localparam int unsigned STATE_BYTES = 16;
  localparam int unsigned MIN_OBJ_LEN = 2;
  localparam int unsigned HALF_BITS = 64;

  localparam logic [7:0] TYPE_MASK_RST = 8'd63;
  localparam logic [7:0] MORE_MASK_RST = 8'd128;
  localparam logic [7:0] MPAN_CODE_RST = 8'd3;
  localparam logic [7:0] MGRP_CODE_RST = 8'd2;

  typedef enum logic [1:0] {
    CFG_TYPE_MASK = 2'd0,
    CFG_MORE_MASK = 2'd1,
    CFG_MPAN_CODE = 2'd2,
    CFG_MGRP_CODE = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RK_SUMMARY = 2'd0,
    RK_HIGH    = 2'd1,
    RK_LOW     = 2'd2
  } result_kind_e;

  typedef struct packed {
    logic [7:0] type_mask;
    logic [7:0] more_mask;
    logic [7:0] mpan_code;
    logic [7:0] mgrp_code;
  } ecs_cfg_t;

  typedef struct packed {
    logic       mpan_hit;
    logic [7:0] mpan_group;
    logic       mgrp_hit;
    logic [7:0] mgrp_group;
  } ecs_find_t;

endpackage

// ----- rtl/ecs_scan.sv -----
module ecs_scan #(
  parameter int unsigned StateBytes = ecs_pkg::STATE_BYTES
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    byte_en_i,
  input  logic                    end_en_i,
  input  logic [7:0]              data_byte_i,
  input  ecs_pkg::ecs_cfg_t       cfg_i,
  output ecs_pkg::ecs_find_t      find_o,
  output logic [StateBytes*8-1:0] state_o
);

  localparam int unsigned StateBits = StateBytes * 8;
  localparam logic [7:0] MinLen = 8'(ecs_pkg::MIN_OBJ_LEN);
  localparam logic [7:0] MpanLen = 8'(ecs_pkg::MIN_OBJ_LEN + 1 + StateBytes);
  localparam logic [7:0] MgrpLen = 8'(ecs_pkg::MIN_OBJ_LEN + 1);
  localparam logic [7:0] LastPos = 8'(StateBytes);

  typedef enum logic [1:0] {
    PH_LEN   = 2'd0,
    PH_FLAGS = 2'd1,
    PH_BODY  = 2'd2
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [7:0]             len_q, len_d;
  logic [7:0]             pos_q, pos_d;
  logic [7:0]             flags_q, flags_d;
  logic                   stopped_q, stopped_d;
  logic [7:0]             pending_q, pending_d;
  ecs_pkg::ecs_find_t     find_q, find_d;
  logic [StateBits-1:0]   state_q, state_d;
  logic                   mpan_cand;
  logic                   mgrp_cand;
  logic [7:0]             pos_inc;
  logic                   obj_done;

  assign mpan_cand = !find_q.mpan_hit && ((flags_q & cfg_i.type_mask) == cfg_i.mpan_code)
                     && (len_q == MpanLen);
  assign mgrp_cand = !find_q.mgrp_hit && ((flags_q & cfg_i.type_mask) == cfg_i.mgrp_code)
                     && (len_q == MgrpLen);
  assign pos_inc  = pos_q + 8'd1;
  assign obj_done = ({1'b0, pos_inc} + {1'b0, MinLen}) >= {1'b0, len_q};

  always_comb begin
    phase_d   = phase_q;
    len_d     = len_q;
    pos_d     = pos_q;
    flags_d   = flags_q;
    stopped_d = stopped_q;
    pending_d = pending_q;
    find_d    = find_q;
    state_d   = state_q;
    if (end_en_i) begin
      phase_d   = PH_LEN;
      len_d     = '0;
      pos_d     = '0;
      flags_d   = '0;
      stopped_d = 1'b0;
      pending_d = '0;
      find_d    = '0;
    end else if (byte_en_i && !stopped_q) begin
      unique case (phase_q)
        PH_LEN: begin
          if (data_byte_i < MinLen) begin
            stopped_d = 1'b1;
          end else begin
            len_d   = data_byte_i;
            pos_d   = '0;
            phase_d = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          flags_d = data_byte_i;
          phase_d = PH_BODY;
          if (len_q == MinLen) begin
            phase_d = PH_LEN;
            pos_d   = '0;
            if ((data_byte_i & cfg_i.more_mask) == 8'd0) begin
              stopped_d = 1'b1;
            end
          end
        end
        PH_BODY: begin
          if (mpan_cand) begin
            if (pos_q == 8'd0) begin
              pending_d = data_byte_i;
            end else if (pos_q <= LastPos) begin
              state_d = {state_q[StateBits-9:0], data_byte_i};
            end
          end
          pos_d = pos_inc;
          if (obj_done) begin
            if (mpan_cand) begin
              find_d.mpan_hit   = 1'b1;
              find_d.mpan_group = pending_q;
            end
            if (mgrp_cand) begin
              find_d.mgrp_hit   = 1'b1;
              find_d.mgrp_group = data_byte_i;
            end
            if ((flags_q & cfg_i.more_mask) == 8'd0) begin
              stopped_d = 1'b1;
            end
            phase_d = PH_LEN;
            pos_d   = '0;
          end
        end
        default: begin
          phase_d = PH_LEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LEN;
      len_q     <= '0;
      pos_q     <= '0;
      flags_q   <= '0;
      stopped_q <= 1'b0;
      pending_q <= '0;
      find_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      len_q     <= len_d;
      pos_q     <= pos_d;
      flags_q   <= flags_d;
      stopped_q <= stopped_d;
      pending_q <= pending_d;
      find_q    <= find_d;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
  end

  assign find_o  = find_q;
  assign state_o = state_q;

endmodule

// ----- rtl/extension_chain_scanner.sv -----
// Data beats are taken one per cycle and update the scan state at the accepting edge.
// An end beat shows its summary beat in the next cycle; two state beats follow when a
// nonce state object was found, one per cycle while the consumer is ready.
// A following end beat waits only while the previous result set is still draining.
// Reset clears the scan control state and result flags and loads the config defaults.
module extension_chain_scanner #(
  parameter int unsigned StateBytes = ecs_pkg::STATE_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_op_i,
  input  logic [7:0]  in_data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_result_kind_o,
  output logic        out_mpan_found_o,
  output logic [7:0]  out_mpan_group_o,
  output logic        out_mgrp_found_o,
  output logic [7:0]  out_mgrp_group_o,
  output logic [63:0] out_state_half_o,
  output logic        out_last_result_o
);

  localparam int unsigned StateBits = StateBytes * 8;
  localparam int unsigned HalfBits = ecs_pkg::HALF_BITS;

  ecs_pkg::ecs_cfg_t        cfg_q;
  ecs_pkg::ecs_find_t       find;
  logic [StateBits-1:0]     state;
  logic                     byte_en;
  logic                     end_en;
  logic                     res_valid_q;
  ecs_pkg::result_kind_e    res_kind_q;
  ecs_pkg::ecs_find_t       res_find_q;
  logic [StateBits-1:0]     res_state_q;
  logic                     res_last;
  logic                     res_free;
  logic                     out_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.type_mask <= ecs_pkg::TYPE_MASK_RST;
      cfg_q.more_mask <= ecs_pkg::MORE_MASK_RST;
      cfg_q.mpan_code <= ecs_pkg::MPAN_CODE_RST;
      cfg_q.mgrp_code <= ecs_pkg::MGRP_CODE_RST;
    end else if (cfg_we_i) begin
      unique case (ecs_pkg::cfg_idx_e'(cfg_idx_i))
        ecs_pkg::CFG_TYPE_MASK: cfg_q.type_mask <= cfg_wdata_i;
        ecs_pkg::CFG_MORE_MASK: cfg_q.more_mask <= cfg_wdata_i;
        ecs_pkg::CFG_MPAN_CODE: cfg_q.mpan_code <= cfg_wdata_i;
        ecs_pkg::CFG_MGRP_CODE: cfg_q.mgrp_code <= cfg_wdata_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  assign res_last = (res_kind_q == ecs_pkg::RK_LOW) ||
                    ((res_kind_q == ecs_pkg::RK_SUMMARY) && !res_find_q.mpan_hit);
  assign out_fire = res_valid_q && out_ready_i;
  assign res_free = !res_valid_q || (out_ready_i && res_last);
  assign in_ready_o = !in_op_i || res_free;
  assign byte_en = in_valid_i && in_ready_o && !in_op_i;
  assign end_en  = in_valid_i && in_ready_o && in_op_i;

  ecs_scan #(
    .StateBytes(StateBytes)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_en_i  (byte_en),
    .end_en_i   (end_en),
    .data_byte_i(in_data_byte_i),
    .cfg_i      (cfg_q),
    .find_o     (find),
    .state_o    (state)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_kind_q  <= ecs_pkg::RK_SUMMARY;
    end else if (end_en) begin
      res_valid_q <= 1'b1;
      res_kind_q  <= ecs_pkg::RK_SUMMARY;
    end else if (out_fire) begin
      if (res_last) begin
        res_valid_q <= 1'b0;
      end else if (res_kind_q == ecs_pkg::RK_SUMMARY) begin
        res_kind_q <= ecs_pkg::RK_HIGH;
      end else begin
        res_kind_q <= ecs_pkg::RK_LOW;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_en) begin
      res_find_q  <= find;
      res_state_q <= state;
    end
  end

  always_comb begin
    out_mpan_found_o = 1'b0;
    out_mpan_group_o = '0;
    out_mgrp_found_o = 1'b0;
    out_mgrp_group_o = '0;
    out_state_half_o = '0;
    unique case (res_kind_q)
      ecs_pkg::RK_SUMMARY: begin
        out_mpan_found_o = res_find_q.mpan_hit;
        out_mpan_group_o = res_find_q.mpan_group;
        out_mgrp_found_o = res_find_q.mgrp_hit;
        out_mgrp_group_o = res_find_q.mgrp_group;
      end
      ecs_pkg::RK_HIGH: out_state_half_o = res_state_q[StateBits-1 -: HalfBits];
      ecs_pkg::RK_LOW:  out_state_half_o = res_state_q[StateBits-HalfBits-1 -: HalfBits];
      default: out_state_half_o = '0;
    endcase
  end

  assign out_valid_o       = res_valid_q;
  assign out_result_kind_o = res_kind_q;
  assign out_last_result_o = res_last;

  a_state_beat_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (res_kind_q != ecs_pkg::RK_SUMMARY) |-> res_find_q.mpan_hit)
    else $error("state beat without a nonce state hit");

  a_end_opens_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_en |=> res_valid_q && (res_kind_q == ecs_pkg::RK_SUMMARY))
    else $error("end beat did not produce a summary beat");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_en |-> !res_valid_q || (out_fire && res_last))
    else $error("end beat taken over an undelivered result");

  a_high_follows_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !end_en && (res_kind_q == ecs_pkg::RK_SUMMARY) && res_find_q.mpan_hit
    |=> res_valid_q && (res_kind_q == ecs_pkg::RK_HIGH))
    else $error("high state beat missing after summary");

endmodule

// ----- sim/scan_result_checker.sv -----
`timescale 1ns / 1ps

module scan_result_checker #(
  parameter logic EndOp = 1'b1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        in_op_i,
  input  logic [7:0]  in_data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  out_result_kind_i,
  input  logic        out_mpan_found_i,
  input  logic [7:0]  out_mpan_group_i,
  input  logic        out_mgrp_found_i,
  input  logic [7:0]  out_mgrp_group_i,
  input  logic [63:0] out_state_half_i,
  input  logic        out_last_result_i,
  output int          failures_o,
  output int          outstanding_o,
  output int          checked_o
);
  import ecs_pkg::*;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_FLAGS,
    PH_BODY
  } hdr_phase_e;

  typedef struct {
    result_kind_e kind;
    logic         mpan_found;
    logic [7:0]   mpan_group;
    logic         mgrp_found;
    logic [7:0]   mgrp_group;
    logic [63:0]  state_half;
    logic         last;
  } scan_report_t;

  scan_report_t report_q[$];

  ecs_cfg_t   cfg;
  hdr_phase_e phase;
  logic [7:0] obj_len;
  logic [7:0] body_pos;
  logic [7:0] obj_flags;
  logic       scan_done;
  logic       nonce_hit;
  logic [7:0] nonce_grp;
  logic [7:0] pend_grp;
  logic       grp_hit;
  logic [7:0] grp_id;
  logic [7:0] nonce_state [STATE_BYTES];

  task automatic clear_scan();
    phase = PH_LEN;
    obj_len = 8'h00;
    body_pos = 8'h00;
    obj_flags = 8'h00;
    scan_done = 1'b0;
    nonce_hit = 1'b0;
    nonce_grp = 8'h00;
    pend_grp = 8'h00;
    grp_hit = 1'b0;
    grp_id = 8'h00;
    foreach (nonce_state[i]) nonce_state[i] = 8'h00;
  endtask

  function automatic logic nonce_candidate();
    return !nonce_hit && (obj_flags & cfg.type_mask) == cfg.mpan_code &&
           int'(obj_len) == MIN_OBJ_LEN + 1 + STATE_BYTES;
  endfunction

  function automatic logic group_candidate();
    return !grp_hit && (obj_flags & cfg.type_mask) == cfg.mgrp_code &&
           int'(obj_len) == MIN_OBJ_LEN + 1;
  endfunction

  function automatic logic [63:0] state_word(input int first);
    logic [63:0] w;
    w = 64'h0;
    for (int i = 0; i < 8; i++) w = {w[55:0], nonce_state[first + i]};
    return w;
  endfunction

  task automatic close_object(input logic [7:0] last_b);
    if (nonce_candidate()) begin
      nonce_hit = 1'b1;
      nonce_grp = pend_grp;
    end
    if (group_candidate()) begin
      grp_hit = 1'b1;
      grp_id = last_b;
    end
    if ((obj_flags & cfg.more_mask) == 8'h00) scan_done = 1'b1;
    phase = PH_LEN;
    body_pos = 8'h00;
  endtask

  task automatic take_byte(input logic [7:0] b);
    if (!scan_done) begin
      case (phase)
        PH_LEN: begin
          if (b < MIN_OBJ_LEN) begin
            scan_done = 1'b1;
          end else begin
            obj_len = b;
            body_pos = 8'h00;
            phase = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          obj_flags = b;
          phase = PH_BODY;
          if (obj_len == MIN_OBJ_LEN) close_object(8'h00);
        end
        default: begin
          if (nonce_candidate()) begin
            if (body_pos == 8'h00) pend_grp = b;
            else if (body_pos - 1 < STATE_BYTES) nonce_state[body_pos - 8'd1] = b;
          end
          body_pos = body_pos + 8'd1;
          if (body_pos + MIN_OBJ_LEN >= obj_len) close_object(b);
        end
      endcase
    end
  endtask

  task automatic emit_report();
    scan_report_t r;
    r.kind = RK_SUMMARY;
    r.mpan_found = nonce_hit;
    r.mpan_group = nonce_hit ? nonce_grp : 8'h00;
    r.mgrp_found = grp_hit;
    r.mgrp_group = grp_hit ? grp_id : 8'h00;
    r.state_half = 64'h0;
    r.last = !nonce_hit;
    report_q.insert(report_q.size(), r);
    if (nonce_hit) begin
      r.mpan_found = 1'b0;
      r.mpan_group = 8'h00;
      r.mgrp_found = 1'b0;
      r.mgrp_group = 8'h00;
      r.kind = RK_HIGH;
      r.state_half = state_word(0);
      r.last = 1'b0;
      report_q.insert(report_q.size(), r);
      r.kind = RK_LOW;
      r.state_half = state_word(8);
      r.last = 1'b1;
      report_q.insert(report_q.size(), r);
    end
    clear_scan();
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      failures_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    scan_report_t want;
    if (!rst_ni) begin
      cfg.type_mask = TYPE_MASK_RST;
      cfg.more_mask = MORE_MASK_RST;
      cfg.mpan_code = MPAN_CODE_RST;
      cfg.mgrp_code = MGRP_CODE_RST;
      clear_scan();
      report_q.delete();
      failures_o = 0;
      checked_o = 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (report_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, kind %0d", $time,
                   out_result_kind_i);
          failures_o++;
        end else begin
          want = report_q.pop_front();
          check_field("result_kind", 64'(want.kind), 64'(out_result_kind_i));
          check_field("mpan_found", 64'(want.mpan_found), 64'(out_mpan_found_i));
          check_field("mpan_group", 64'(want.mpan_group), 64'(out_mpan_group_i));
          check_field("mgrp_found", 64'(want.mgrp_found), 64'(out_mgrp_found_i));
          check_field("mgrp_group", 64'(want.mgrp_group), 64'(out_mgrp_group_i));
          check_field("state_half", want.state_half, out_state_half_i);
          check_field("last_result", 64'(want.last), 64'(out_last_result_i));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TYPE_MASK: cfg.type_mask = cfg_wdata_i;
          CFG_MORE_MASK: cfg.more_mask = cfg_wdata_i;
          CFG_MPAN_CODE: cfg.mpan_code = cfg_wdata_i;
          CFG_MGRP_CODE: cfg.mgrp_code = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (in_op_i == EndOp) emit_report();
        else take_byte(in_data_byte_i);
      end
      outstanding_o <= report_q.size();
    end
  end

endmodule

// ----- sim/tb_extension_chain_scanner.sv -----
`timescale 1ns / 1ps

module tb_extension_chain_scanner;
  import ecs_pkg::*;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;
  localparam int PHASE_BEATS = 20;
  localparam int HOLD_CYCLES = 200;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int NONCE_OBJ_LEN = MIN_OBJ_LEN + 1 + STATE_BYTES;
  localparam int GROUP_OBJ_LEN = MIN_OBJ_LEN + 1;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        in_op_i;
  logic [7:0]  in_data_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  out_result_kind_o;
  logic        out_mpan_found_o;
  logic [7:0]  out_mpan_group_o;
  logic        out_mgrp_found_o;
  logic [7:0]  out_mgrp_group_o;
  logic [63:0] out_state_half_o;
  logic        out_last_result_o;

  int failures;
  int outstanding;
  int checked;
  int beats_sent;
  int ends_sent;
  int rx_hold_cycles;
  int stall_cycles = 0;
  bit idle_en;
  logic [7:0] cur_type_mask;
  logic [7:0] cur_more_mask;
  logic [7:0] cur_mpan_code;
  logic [7:0] cur_mgrp_code;

  always #6 clk_i = ~clk_i;

  extension_chain_scanner uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_op_i           (in_op_i),
    .in_data_byte_i    (in_data_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_result_kind_o (out_result_kind_o),
    .out_mpan_found_o  (out_mpan_found_o),
    .out_mpan_group_o  (out_mpan_group_o),
    .out_mgrp_found_o  (out_mgrp_found_o),
    .out_mgrp_group_o  (out_mgrp_group_o),
    .out_state_half_o  (out_state_half_o),
    .out_last_result_o (out_last_result_o)
  );

  scan_result_checker #(
    .EndOp(OP_END)
  ) checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .in_op_i           (in_op_i),
    .in_data_byte_i    (in_data_byte_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_result_kind_i (out_result_kind_o),
    .out_mpan_found_i  (out_mpan_found_o),
    .out_mpan_group_i  (out_mpan_group_o),
    .out_mgrp_found_i  (out_mgrp_found_o),
    .out_mgrp_group_i  (out_mgrp_group_o),
    .out_state_half_i  (out_state_half_o),
    .out_last_result_i (out_last_result_o),
    .failures_o        (failures),
    .outstanding_o     (outstanding),
    .checked_o         (checked)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // The receiver can be told to hold off for a long stretch after its next beat.
  initial begin
    int gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end
      gap = idle_en ? $urandom_range(0, 5) : 0;
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  task automatic send_beat(input logic op, input logic [7:0] b);
    int gap;
    gap = idle_en ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_op_i <= op;
    in_data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    if (op == OP_END) ends_sent++;
  endtask

  task automatic send_object(input int len, input logic [7:0] ty, input bit more_bit,
                             input int cut);
    logic [7:0] flags;
    logic [7:0] free_more;
    flags = (8'($urandom) & ~cur_type_mask) | (ty & cur_type_mask);
    free_more = cur_more_mask & ~cur_type_mask;
    if (more_bit) flags = flags | ((free_more != 8'h00) ? free_more : cur_more_mask);
    else flags = flags & ~cur_more_mask;
    send_beat(OP_DATA, 8'(len));
    if (cut > 1) send_beat(OP_DATA, flags);
    for (int sent = 2; sent < len && sent < cut; sent++) send_beat(OP_DATA, 8'($urandom));
  endtask

  task automatic send_chain(input bit nonce_first);
    int n;
    int pick;
    int len;
    logic [7:0] ty;
    bit more_bit;
    bit cut_short;
    n = $urandom_range(1, 5);
    cut_short = 1'b0;
    for (int i = 0; i < n && !cut_short; i++) begin
      pick = (nonce_first && i == 0) ? 0 : $urandom_range(0, 11);
      more_bit = (i != n - 1) ^ ($urandom_range(0, 9) == 0);
      case (pick)
        0, 1, 2, 3: send_object(NONCE_OBJ_LEN, cur_mpan_code, more_bit, NONCE_OBJ_LEN);
        4, 5, 6: send_object(GROUP_OBJ_LEN, cur_mgrp_code, more_bit, GROUP_OBJ_LEN);
        7: begin
          len = $urandom_range(MIN_OBJ_LEN, 24);
          ty = $urandom_range(0, 1) ? cur_mpan_code : cur_mgrp_code;
          send_object(len, ty, more_bit, len);
        end
        8, 9: begin
          len = $urandom_range(MIN_OBJ_LEN, 8);
          send_object(len, 8'($urandom), more_bit, len);
        end
        10: begin
          send_beat(OP_DATA, 8'($urandom_range(0, MIN_OBJ_LEN - 1)));
          cut_short = 1'b1;
        end
        default: begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 255) : NONCE_OBJ_LEN;
          send_object(len, cur_mpan_code, 1'b1, $urandom_range(1, (len > 30 ? 30 : len) - 1));
          cut_short = 1'b1;
        end
      endcase
    end
    if (!cut_short && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_beat(OP_DATA, 8'($urandom));
    end
    send_beat(OP_END, 8'($urandom));
  endtask

  task automatic settle(input int extra);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic load_config(input logic [7:0] tmask, input logic [7:0] mmask,
                             input logic [7:0] pcode, input logic [7:0] gcode);
    cur_type_mask = tmask;
    cur_more_mask = mmask;
    cur_mpan_code = pcode;
    cur_mgrp_code = gcode;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_TYPE_MASK;
    cfg_wdata_i <= tmask;
    @(posedge clk_i);
    cfg_idx_i <= CFG_MORE_MASK;
    cfg_wdata_i <= mmask;
    @(posedge clk_i);
    cfg_idx_i <= CFG_MPAN_CODE;
    cfg_wdata_i <= pcode;
    @(posedge clk_i);
    cfg_idx_i <= CFG_MGRP_CODE;
    cfg_wdata_i <= gcode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int phase_start;
    logic [7:0] tmask;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_TYPE_MASK;
    cfg_wdata_i = 8'h00;
    in_valid_i = 1'b0;
    in_op_i = OP_DATA;
    in_data_byte_i = 8'h00;
    cur_type_mask = TYPE_MASK_RST;
    cur_more_mask = MORE_MASK_RST;
    cur_mpan_code = MPAN_CODE_RST;
    cur_mgrp_code = MGRP_CODE_RST;
    idle_en = 1'b0;
    rx_hold_cycles = 0;
    beats_sent = 0;
    ends_sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // An empty area, then a group object followed by a nonce state object that stops
    // the scan, a stray beat after the stop, and the end beat.
    send_beat(OP_END, 8'hFF);
    send_beat(OP_DATA, 8'(GROUP_OBJ_LEN));
    send_beat(OP_DATA, MORE_MASK_RST | MGRP_CODE_RST);
    send_beat(OP_DATA, 8'hFF);
    send_beat(OP_DATA, 8'(NONCE_OBJ_LEN));
    send_beat(OP_DATA, MPAN_CODE_RST);
    send_beat(OP_DATA, 8'h00);
    for (int i = 0; i < STATE_BYTES; i++) send_beat(OP_DATA, i[0] ? 8'(i) : ~8'(i));
    send_beat(OP_DATA, 8'h01);
    send_beat(OP_END, 8'h00);
    settle(4);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_config(TYPE_MASK_RST, MORE_MASK_RST, MPAN_CODE_RST, MGRP_CODE_RST);
        1: load_config(8'hFF, 8'h00, 8'hFF, 8'h00);
        2: load_config(8'h00, 8'hFF, 8'h00, 8'h00);
        3: load_config(8'h0F, 8'h40, 8'h0A, 8'h05);
        default: begin
          tmask = 8'($urandom);
          load_config(tmask, 8'($urandom), 8'($urandom) & tmask, 8'($urandom) & tmask);
        end
      endcase
      idle_en = (phase != 1);
      if (phase == 0) begin
        idle_en = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (4) send_chain(1'b1);
        idle_en = 1'b1;
      end
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) send_chain(1'b0);
      settle(4);
    end
    repeat (16) @(posedge clk_i);

    $display("Drove %0d beats with %0d end beats under six register settings,", beats_sent,
             ends_sent);
    $display("including a %0d-cycle receiver hold; %0d result beats were compared.",
             HOLD_CYCLES, checked);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
